// File: hdl/tfs_pkg.sv
// tfs_pkg: shared constants and stage payload types for the triangular fuzzy set evaluator
// depends on nothing; imported by tfs_front, tfs_div and triangle_fuzzy_set_eval
`timescale 1ns / 1ps

package tfs_pkg;

    localparam int FRAC_BITS = 16;
    localparam int DEG_W     = FRAC_BITS + 1;
    localparam int VAL_W     = 32;
    localparam int AREA_W    = 31;
    localparam int NUM_W     = 54;
    localparam int MAG_W     = 52;
    localparam int DEN_W     = 19;
    localparam int CQ_W      = 35;
    localparam int MQ_W      = FRAC_BITS;
    localparam int MR_W      = 32;
    localparam int CFG_IDX_W = 2;

    localparam logic [DEG_W-1:0]  ONE       = DEG_W'(1) << FRAC_BITS;
    localparam logic [AREA_W-1:0] AREA_MAX  = '1;
    localparam logic [VAL_W-1:0]  CEN_MAX   = 32'h7FFF_FFFF;
    localparam logic [VAL_W-1:0]  CEN_MIN   = 32'h8000_0000;

    localparam logic [CFG_IDX_W-1:0] CFG_LEFT   = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_CENTER = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_RIGHT  = 2'd2;

    // operands of the centroid division, plus the fixed membership and the area, carried through the membership divider
    typedef struct packed {
        logic              mem_fix;
        logic [DEG_W-1:0]  mem_fixval;
        logic [AREA_W-1:0] area;
        logic              neg;
        logic [MAG_W-1:0]  mag;
        logic [DEN_W-1:0]  den;
    } t_mem_pay;

    // finished fields carried through the centroid divider
    typedef struct packed {
        logic [DEG_W-1:0]  membership;
        logic [AREA_W-1:0] area;
        logic              neg;
    } t_cen_pay;

    typedef struct packed {
        t_mem_pay         pay;
        logic [MR_W-1:0]  mem_a;
        logic [MR_W-1:0]  mem_d;
    } t_front_out;

endpackage

// File: hdl/tfs_front.sv
// tfs_front: four register stages of case selection, products and centroid numerator
// depends on tfs_pkg
`timescale 1ns / 1ps

module tfs_front (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_en,
    input  logic                         i_vld,
    input  logic [tfs_pkg::VAL_W-1:0]    i_x,
    input  logic [tfs_pkg::DEG_W-1:0]    i_d,
    input  logic [tfs_pkg::VAL_W-1:0]    i_left,
    input  logic [tfs_pkg::VAL_W-1:0]    i_center,
    input  logic [tfs_pkg::VAL_W-1:0]    i_right,
    output logic                         o_vld,
    output tfs_pkg::t_front_out          o_res
);
    import tfs_pkg::*;

    // stage 1 comb
    logic signed [33:0] x_s, l_s, c_s, r_s;
    logic [MR_W-1:0]    n_a, n_dv;
    logic               n_fix;
    logic [DEG_W-1:0]   n_fixval, n_dcl;

    // stage 1 regs
    logic               r1_vld, r1_fix, r1_wpos;
    logic [MR_W-1:0]    r1_a, r1_dv, r1_w;
    logic [DEG_W-1:0]   r1_fixval, r1_d;
    logic [DEG_W:0]     r1_dcomp;
    logic signed [33:0] r1_lr, r1_rcl;
    logic signed [34:0] r1_rccl;

    // stage 2 regs
    logic               r2_vld, r2_fix, r2_wpos;
    logic [MR_W-1:0]    r2_a, r2_dv, r2_w;
    logic [DEG_W-1:0]   r2_fixval;
    logic [DEG_W:0]     r2_dcomp;
    logic signed [33:0] r2_lr;
    logic signed [34:0] r2_rccl;
    logic [34:0]        r2_pq;
    logic [33:0]        r2_dd;
    logic signed [51:0] r2_t2;

    // stage 3 regs
    logic               r3_vld, r3_fix, r3_wpos;
    logic [MR_W-1:0]    r3_a, r3_dv;
    logic [DEG_W-1:0]   r3_fixval;
    logic [DEG_W:0]     r3_dcomp;
    logic signed [33:0] r3_lr;
    logic signed [51:0] r3_t2;
    logic [48:0]        r3_area_raw;
    logic signed [52:0] r3_t3;

    // stage 4 comb
    logic signed [NUM_W-1:0] lr_x, t2_x, num;
    logic [NUM_W-1:0]        num_abs;
    logic [AREA_W-1:0]       n_area;
    logic [DEN_W-1:0]        n_den;

    // stage 4 regs
    logic       r4_vld;
    t_front_out r4_res;

    always_comb begin
        x_s = $signed({{2{i_x[31]}}, i_x});
        l_s = $signed({{2{i_left[31]}}, i_left});
        c_s = $signed({{2{i_center[31]}}, i_center});
        r_s = $signed({{2{i_right[31]}}, i_right});
        n_a      = '0;
        n_dv     = MR_W'(1);
        n_fix    = 1'b1;
        n_fixval = '0;
        if (x_s < c_s && x_s > l_s) begin
            n_a   = MR_W'(x_s - l_s);
            n_dv  = MR_W'(c_s - l_s);
            n_fix = 1'b0;
        end else if (x_s > c_s && x_s < r_s) begin
            n_a   = MR_W'(r_s - x_s);
            n_dv  = MR_W'(r_s - c_s);
            n_fix = 1'b0;
        end else if (x_s == c_s) begin
            n_fixval = ONE;
        end
        n_dcl = (i_d > ONE) ? ONE : i_d;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r1_vld <= 1'b0;
            r2_vld <= 1'b0;
            r3_vld <= 1'b0;
            r4_vld <= 1'b0;
        end else if (i_en) begin
            r1_vld <= i_vld;
            r2_vld <= r1_vld;
            r3_vld <= r2_vld;
            r4_vld <= r3_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            // stage 1: case select, corner sums
            r1_a      <= n_a;
            r1_dv     <= n_dv;
            r1_fix    <= n_fix;
            r1_fixval <= n_fixval;
            r1_d      <= n_dcl;
            r1_dcomp  <= {ONE, 1'b0} - {1'b0, n_dcl};
            r1_lr     <= l_s + r_s;
            r1_rcl    <= r_s - c_s + l_s;
            r1_rccl   <= 35'(r_s) - (35'(c_s) <<< 1) + 35'(l_s);
            r1_w      <= MR_W'(r_s - l_s);
            r1_wpos   <= r_s > l_s;
            // stage 2: degree products
            r2_a      <= r1_a;
            r2_dv     <= r1_dv;
            r2_fix    <= r1_fix;
            r2_fixval <= r1_fixval;
            r2_dcomp  <= r1_dcomp;
            r2_lr     <= r1_lr;
            r2_rccl   <= r1_rccl;
            r2_w      <= r1_w;
            r2_wpos   <= r1_wpos;
            r2_pq     <= 35'({18'd0, r1_d} * {17'd0, r1_dcomp});
            r2_dd     <= 34'({17'd0, r1_d} * {17'd0, r1_d});
            r2_t2     <= 52'(r1_rcl * $signed({1'b0, r1_d}));
            // stage 3: area product, squared-degree term
            r3_a        <= r2_a;
            r3_dv       <= r2_dv;
            r3_fix      <= r2_fix;
            r3_fixval   <= r2_fixval;
            r3_dcomp    <= r2_dcomp;
            r3_lr       <= r2_lr;
            r3_t2       <= r2_t2;
            r3_wpos     <= r2_wpos;
            r3_area_raw <= 49'({17'd0, r2_w} * {32'd0, r2_pq[32:16]});
            r3_t3       <= 53'(r2_rccl * $signed({1'b0, r2_dd[32:16]}));
            // stage 4: numerator, area saturation
            r4_res.mem_a          <= r3_a;
            r4_res.mem_d          <= r3_dv;
            r4_res.pay.mem_fix    <= r3_fix;
            r4_res.pay.mem_fixval <= r3_fixval;
            r4_res.pay.area       <= n_area;
            r4_res.pay.neg        <= num[NUM_W-1];
            r4_res.pay.mag        <= num_abs[MAG_W-1:0];
            r4_res.pay.den        <= n_den;
        end
    end

    always_comb begin
        lr_x    = $signed({{4{r3_lr[33]}}, r3_lr, 16'd0});
        t2_x    = $signed({{2{r3_t2[51]}}, r3_t2});
        num     = (lr_x + (lr_x <<< 1)) - (t2_x + (t2_x <<< 1))
                  + $signed({r3_t3[52], r3_t3});
        num_abs = num[NUM_W-1] ? NUM_W'(-num) : NUM_W'(num);
        if (!r3_wpos)
            n_area = '0;
        else if (r3_area_raw[48])
            n_area = AREA_MAX;
        else
            n_area = r3_area_raw[47:17];
        n_den = DEN_W'({1'b0, r3_dcomp}) + DEN_W'({r3_dcomp, 1'b0});
    end

    assign o_vld = r4_vld;
    assign o_res = r4_res;

endmodule

// File: hdl/tfs_div.sv
// tfs_div: pipelined restoring divider, one quotient bit per register stage
// depends on tfs_pkg
`timescale 1ns / 1ps

module tfs_div #(
    parameter int RW    = 32,
    parameter int STEPS = 16,
    parameter int PW    = 8
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_en,
    input  logic             i_vld,
    input  logic [RW-1:0]    i_rem0,
    input  logic [STEPS-1:0] i_feed,
    input  logic [RW-1:0]    i_den,
    input  logic [PW-1:0]    i_pay,
    output logic             o_vld,
    output logic [STEPS-1:0] o_quo,
    output logic [PW-1:0]    o_pay
);
    import tfs_pkg::*;

    // feed bits shift out of the top of r_q while quotient bits shift in below
    logic             r_vld [STEPS];
    logic [RW-1:0]    r_rem [STEPS];
    logic [RW-1:0]    r_den [STEPS];
    logic [STEPS-1:0] r_q   [STEPS];
    logic [PW-1:0]    r_pay [STEPS];

    for (genvar k = 0; k < STEPS; k++) begin : g_stage
        logic             s_vld;
        logic [RW-1:0]    s_rem, s_den;
        logic [STEPS-1:0] s_q;
        logic [PW-1:0]    s_pay;
        logic [RW:0]      rem2;
        logic             ge;

        if (k == 0) begin : g_first
            assign s_vld = i_vld;
            assign s_rem = i_rem0;
            assign s_den = i_den;
            assign s_q   = i_feed;
            assign s_pay = i_pay;
        end else begin : g_next
            assign s_vld = r_vld[k-1];
            assign s_rem = r_rem[k-1];
            assign s_den = r_den[k-1];
            assign s_q   = r_q[k-1];
            assign s_pay = r_pay[k-1];
        end

        assign rem2 = {s_rem, s_q[STEPS-1]};
        assign ge   = rem2 >= {1'b0, s_den};

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_vld[k] <= 1'b0;
            end else if (i_en) begin
                r_vld[k] <= s_vld;
            end
        end

        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r_rem[k] <= ge ? RW'(rem2 - {1'b0, s_den}) : RW'(rem2);
                r_den[k] <= s_den;
                r_q[k]   <= {s_q[STEPS-2:0], ge};
                r_pay[k] <= s_pay;
            end
        end
    end

    assign o_vld = r_vld[STEPS-1];
    assign o_quo = r_q[STEPS-1];
    assign o_pay = r_pay[STEPS-1];

endmodule

// File: hdl/triangle_fuzzy_set_eval.sv
// triangle_fuzzy_set_eval: top level, config registers, divider chain, output register
// depends on tfs_pkg, tfs_front, tfs_div
`timescale 1ns / 1ps
//
// channel   dir  handshake                          contents
// s_axis    in   i_s_axis_tvalid / o_s_axis_tready  crisp_value, degree
// m_axis    out  o_m_axis_tvalid / i_m_axis_tready  membership, clipped_area, center_of_area
// cfg       in   i_cfg_we                           left_corner, center_peak, right_corner
//
// the path runs through 4 front stages, 16 membership quotient stages,
// 35 centroid quotient stages and the output register
// one item per cycle while the output is not held; the centroid divider is the longest part
// synchronous active-low reset clears every valid bit and loads the default triangle
// a held output freezes the whole pipe in place; ready follows the output register
//
module triangle_fuzzy_set_eval (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_s_axis_tvalid,
    output logic                            o_s_axis_tready,
    // [31:0] crisp_value, [48:32] degree, [55:49] zero
    input  logic [55:0]                     i_s_axis_tdata,
    output logic                            o_m_axis_tvalid,
    input  logic                            i_m_axis_tready,
    // [16:0] membership, [47:17] clipped_area, [79:48] center_of_area
    output logic [79:0]                     o_m_axis_tdata,
    input  logic                            i_cfg_we,
    input  logic [tfs_pkg::CFG_IDX_W-1:0]   i_cfg_idx,
    input  logic [tfs_pkg::VAL_W-1:0]       i_cfg_data
);
    import tfs_pkg::*;

    // triangle corners
    logic [VAL_W-1:0] r_left, r_center, r_right;

    // one enable for the whole pipe: move when the output slot is free or drained
    logic en;

    logic       front_vld;
    t_front_out front_res;

    logic             mdiv_vld;
    logic [MQ_W-1:0]  mdiv_quo;
    logic [$bits(t_mem_pay)-1:0] mdiv_pay_bits;
    t_mem_pay         mdiv_pay;

    t_cen_pay         cdiv_in;
    logic             cdiv_vld;
    logic [CQ_W-1:0]  cdiv_quo;
    logic [$bits(t_cen_pay)-1:0] cdiv_pay_bits;
    t_cen_pay         cdiv_pay;

    logic [VAL_W-1:0] n_center_of_area;

    logic              r_out_vld;
    logic [DEG_W-1:0]  r_membership;
    logic [AREA_W-1:0] r_clipped_area;
    logic [VAL_W-1:0]  r_center_of_area;

    assign en = !r_out_vld || i_m_axis_tready;

    // config writes, out-of-list index is dropped
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_left   <= 32'hFFFF_0000;
            r_center <= 32'h0000_0000;
            r_right  <= 32'h0001_0000;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                CFG_LEFT:   r_left   <= i_cfg_data;
                CFG_CENTER: r_center <= i_cfg_data;
                CFG_RIGHT:  r_right  <= i_cfg_data;
                default:    ;
            endcase
        end
    end

    tfs_front u_front (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_en     (en),
        .i_vld    (i_s_axis_tvalid),
        .i_x      (i_s_axis_tdata[31:0]),
        .i_d      (i_s_axis_tdata[48:32]),
        .i_left   (r_left),
        .i_center (r_center),
        .i_right  (r_right),
        .o_vld    (front_vld),
        .o_res    (front_res)
    );

    // membership quotient: remainder starts at the distance, fraction bits shift in as zeros
    tfs_div #(
        .RW    (MR_W),
        .STEPS (MQ_W),
        .PW    ($bits(t_mem_pay))
    ) u_mdiv (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (en),
        .i_vld   (front_vld),
        .i_rem0  (front_res.mem_a),
        .i_feed  ('0),
        .i_den   (front_res.mem_d),
        .i_pay   (front_res.pay),
        .o_vld   (mdiv_vld),
        .o_quo   (mdiv_quo),
        .o_pay   (mdiv_pay_bits)
    );

    assign mdiv_pay = t_mem_pay'(mdiv_pay_bits);

    always_comb begin
        cdiv_in.membership = mdiv_pay.mem_fix ? mdiv_pay.mem_fixval : {1'b0, mdiv_quo};
        cdiv_in.area       = mdiv_pay.area;
        cdiv_in.neg        = mdiv_pay.neg;
    end

    // centroid magnitude quotient: top bits of the numerator are already below the divisor
    tfs_div #(
        .RW    (DEN_W),
        .STEPS (CQ_W),
        .PW    ($bits(t_cen_pay))
    ) u_cdiv (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (en),
        .i_vld   (mdiv_vld),
        .i_rem0  (DEN_W'(mdiv_pay.mag[MAG_W-1:CQ_W])),
        .i_feed  (mdiv_pay.mag[CQ_W-1:0]),
        .i_den   (mdiv_pay.den),
        .i_pay   (cdiv_in),
        .o_vld   (cdiv_vld),
        .o_quo   (cdiv_quo),
        .o_pay   (cdiv_pay_bits)
    );

    assign cdiv_pay = t_cen_pay'(cdiv_pay_bits);

    // restore sign, saturate to 32 bits
    always_comb begin
        if (!cdiv_pay.neg) begin
            if (cdiv_quo > CQ_W'(CEN_MAX))
                n_center_of_area = CEN_MAX;
            else
                n_center_of_area = cdiv_quo[VAL_W-1:0];
        end else begin
            if (cdiv_quo > CQ_W'(CEN_MIN))
                n_center_of_area = CEN_MIN;
            else
                n_center_of_area = VAL_W'(0) - cdiv_quo[VAL_W-1:0];
        end
    end

    // output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_vld <= 1'b0;
        end else if (en) begin
            r_out_vld <= cdiv_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_membership     <= cdiv_pay.membership;
            r_clipped_area   <= cdiv_pay.area;
            r_center_of_area <= n_center_of_area;
        end
    end

    assign o_s_axis_tready = en;
    assign o_m_axis_tvalid = r_out_vld;
    assign o_m_axis_tdata  = {r_center_of_area, r_clipped_area, r_membership};

    // membership never exceeds one
    a_mem_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_vld |-> r_membership <= ONE)
        else $error("membership above one");

    // a stalled result stays and does not change
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_vld && !i_m_axis_tready |=> r_out_vld && $stable(o_m_axis_tdata))
        else $error("stalled result lost or changed");

    // reset empties the pipe
    a_rst_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_m_axis_tvalid)
        else $error("result valid after reset");

endmodule
